### hdl/hks_pkg.sv
package hks_pkg;

	// Width of the rank register
	localparam int RANK_W = 11;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BUILD,
		ST_ELEM,
		ST_CHILD,
		ST_RDR,
		ST_CMP,
		ST_PLACE,
		ST_EXTRACT,
		ST_RES
	} state_t;

	// Which pass a sift-down returns to
	typedef enum logic {
		PH_BUILD,
		PH_EXTRACT
	} phase_t;

endpackage

### hdl/hks_ifs.sv
interface hks_item_if #(
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 32
) ();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] item_key;
	logic [ID_BITS-1:0]  item_id;
	logic                last_item;

	modport source (output valid, item_key, item_id, last_item, input ready);
	modport sink   (input valid, item_key, item_id, last_item, output ready);
endinterface

interface hks_result_if #(
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 32
) ();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] kth_key;
	logic [ID_BITS-1:0]  kth_id;
	logic                found;
	logic                overflowed;

	modport source (output valid, kth_key, kth_id, found, overflowed, input ready);
	modport sink   (input valid, kth_key, kth_id, found, overflowed, output ready);
endinterface

interface hks_cfg_if import hks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;

	modport source (output valid, rank, input ready);
	modport sink   (input valid, rank, output ready);
endinterface

### hdl/hks_ram.sv
module hks_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/heap_kth_smallest_select.sv
// Loading takes one beat per cycle; input stalls from the closing beat until the result
// enters the output register.
// After the closing beat: a bottom-up heap build, then (rank-1) removals of the minimum,
// all on one RAM port pair and one shared key comparator; the root is then read and
// registered as the result. Both passes are skipped when rank exceeds the item count.
// Reset clears the sequencer, the item count, the overflow flag and the output valid,
// and sets rank to 1; the heap RAM is not cleared.
module heap_kth_smallest_select import hks_pkg::*; #(
	parameter int DEPTH    = 1024,
	parameter int KEY_BITS = 32,
	parameter int ID_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	hks_cfg_if.sink      cfg_ch,
	hks_item_if.sink     item_ch,
	hks_result_if.source result_ch
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;
	localparam int WW = (RANK_W > CW) ? RANK_W : CW;
	localparam int EW = KEY_BITS + ID_BITS;

	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [RANK_W-1:0] rank_q;
	logic [CW-1:0]     count_q;
	logic              ovf_seen_q;
	logic              ovf_res_q;
	logic              found_q;
	logic [CW-1:0]     size_q;
	logic [CW-1:0]     bi_q;
	logic [RANK_W-1:0] ext_left_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     bidx_q;
	logic [EW-1:0]     elem_q;
	logic [EW-1:0]     best_q;
	logic              rvalid_q;

	logic              out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [ID_BITS-1:0]  out_id_q;
	logic              out_found_q;
	logic              out_ovf_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [EW-1:0]     ram_rdata;

	logic              item_acc;
	logic              room;
	logic [CW-1:0]     size_n;
	logic              ovf_n;
	logic [RANK_W-1:0] want;
	logic              not_found;
	logic [IW-1:0]     lidx;
	logic [IW-1:0]     ridx;
	logic              l_ok;
	logic              r_ok;
	logic [KEY_BITS-1:0] cmp_ref;
	logic              cmp_lt;
	logic              take_r;
	logic [AW-1:0]     fin_idx;
	logic [EW-1:0]     fin_ent;
	logic              out_load;

	hks_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Load-side bookkeeping
	assign item_acc  = item_ch.valid && item_ch.ready;
	assign room      = count_q < CW'(DEPTH);
	assign size_n    = room ? count_q + 1'b1 : count_q;
	assign ovf_n     = ovf_seen_q || !room;
	assign want      = (rank_q == '0) ? RANK_W'(1) : rank_q;
	assign not_found = WW'(want) > WW'(size_n);

	// Child indexes and the shared comparator
	assign lidx    = IW'({cur_q, 1'b1});
	assign ridx    = IW'({cur_q, 1'b0}) + IW'(2);
	assign l_ok    = lidx < IW'(size_q);
	assign r_ok    = ridx < IW'(size_q);
	assign cmp_ref = (state_q == ST_RDR) ? elem_q[EW-1 -: KEY_BITS]
	                                     : best_q[EW-1 -: KEY_BITS];
	assign cmp_lt  = ram_rdata[EW-1 -: KEY_BITS] < cmp_ref;
	assign take_r  = rvalid_q && cmp_lt;
	assign fin_idx = take_r ? ridx[AW-1:0] : bidx_q;
	assign fin_ent = take_r ? ram_rdata : best_q;

	assign out_load = !out_valid_q || result_ch.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (item_acc && item_ch.last_item) begin
					state_d = not_found ? ST_RES : ST_BUILD;
				end
			end
			ST_BUILD: begin
				state_d = (bi_q == '0) ? ST_EXTRACT : ST_ELEM;
			end
			ST_ELEM: begin
				state_d = ST_CHILD;
			end
			ST_CHILD: begin
				state_d = l_ok ? ST_RDR : ST_PLACE;
			end
			ST_RDR: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = (fin_idx == cur_q) ? ST_PLACE : ST_CHILD;
			end
			ST_PLACE: begin
				state_d = (phase_q == PH_BUILD) ? ST_BUILD : ST_EXTRACT;
			end
			ST_EXTRACT: begin
				state_d = (ext_left_q == '0) ? ST_RES : ST_ELEM;
			end
			ST_RES: begin
				if (out_load) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// RAM port control and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = elem_q;
		ram_raddr = '0;
		case (state_q)
			ST_LOAD: begin
				ram_we    = item_acc && room;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {item_ch.item_key, item_ch.item_id};
			end
			ST_BUILD: begin
				ram_raddr = bi_q[AW-1:0] - 1'b1;
			end
			ST_EXTRACT: begin
				if (ext_left_q != '0) begin
					ram_raddr = size_q[AW-1:0] - 1'b1;
				end
			end
			ST_CHILD: begin
				ram_raddr = lidx[AW-1:0];
			end
			ST_RDR: begin
				ram_raddr = ridx[AW-1:0];
			end
			ST_CMP: begin
				ram_we    = fin_idx != cur_q;
				ram_wdata = fin_ent;
			end
			ST_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	assign item_ch.ready = state_q == ST_LOAD;
	assign cfg_ch.ready  = 1'b1;

	assign result_ch.valid      = out_valid_q;
	assign result_ch.kth_key    = out_key_q;
	assign result_ch.kth_id     = out_id_q;
	assign result_ch.found      = out_found_q;
	assign result_ch.overflowed = out_ovf_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rank_q      <= RANK_W'(1);
			count_q     <= '0;
			ovf_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_ch.valid) begin
				rank_q <= cfg_ch.rank;
			end
			if (item_acc) begin
				if (item_ch.last_item) begin
					count_q    <= '0;
					ovf_seen_q <= 1'b0;
				end else begin
					count_q    <= size_n;
					ovf_seen_q <= ovf_n;
				end
			end
			if (state_q == ST_RES && out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (item_acc && item_ch.last_item) begin
					size_q     <= size_n;
					bi_q       <= size_n >> 1;
					ext_left_q <= want - 1'b1;
					ovf_res_q  <= ovf_n;
					found_q    <= !not_found;
					phase_q    <= PH_BUILD;
				end
			end
			ST_BUILD: begin
				if (bi_q != '0) begin
					bi_q  <= bi_q - 1'b1;
					cur_q <= bi_q[AW-1:0] - 1'b1;
				end
			end
			ST_EXTRACT: begin
				phase_q <= PH_EXTRACT;
				if (ext_left_q != '0) begin
					ext_left_q <= ext_left_q - 1'b1;
					size_q     <= size_q - 1'b1;
					cur_q      <= '0;
				end
			end
			ST_ELEM: begin
				elem_q <= ram_rdata;
			end
			ST_RDR: begin
				bidx_q   <= cmp_lt ? lidx[AW-1:0] : cur_q;
				best_q   <= cmp_lt ? ram_rdata : elem_q;
				rvalid_q <= r_ok;
			end
			ST_CMP: begin
				cur_q <= fin_idx;
			end
			ST_RES: begin
				if (out_load) begin
					out_key_q   <= found_q ? ram_rdata[EW-1 -: KEY_BITS] : '0;
					out_id_q    <= found_q ? ram_rdata[ID_BITS-1:0] : '0;
					out_found_q <= found_q;
					out_ovf_q   <= ovf_res_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule
